FILE: design/quaternion_slerp_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion slerp block
// Shared property wrappers, sampled on clock and held off during reset.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_SLERP_TOP_ASSERT_SVH
`define QUATERNION_SLERP_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define QS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause
`define QS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/qslerp_pkg.sv
// ---------------------------------------------------------------------------
// qslerp_pkg
// Types, constants and helpers shared by the quaternion slerp pipeline.
// ---------------------------------------------------------------------------
package qslerp_pkg;

   localparam int FRACTION_BITS   = 14;
   localparam int WP              = 30;
   localparam int CORDIC_STEPS    = 30;
   localparam int STEPS_PER_STAGE = 2;
   localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
   localparam int SQRT_STEPS      = 32;
   localparam int SQRT_STAGES     = SQRT_STEPS / STEPS_PER_STAGE;
   localparam int DIV_STEPS       = 32;
   localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE + 1;
   localparam int FRONT_STAGES    = 6;
   localparam int ANGLE_STAGES    = 2 * CORDIC_STAGES + 1;
   localparam int BACK_STAGES     = 4;
   localparam int LANES           = 4;

   typedef logic signed [15:0] q16_type;
   typedef logic signed [16:0] q17_type;
   typedef logic signed [26:0] r_type;
   typedef logic signed [33:0] w_type;
   typedef logic signed [35:0] p36_type;
   typedef logic signed [50:0] pw_type;
   typedef logic [53:0]        sq_type;

   localparam logic [14:0] THRESHOLD_RESET = 15'd16376;
   localparam logic [16:0] FRACTION_ONE    = 17'd65536;
   localparam logic [35:0] DOT_ONE         = 36'd1 << (2 * FRACTION_BITS);
   localparam logic [30:0] W_ONE           = 31'd1 << WP;
   localparam logic [61:0] SQ_ONE          = 62'd1 << (2 * WP);
   localparam w_type       CORDIC_GAIN_INV = 34'sd652032874;
   localparam logic [30:0] HALF_PI_W       = 31'd1686629713;
   localparam q16_type     SAT_HI          = 16'sd16384;

   localparam w_type ATAN_TAB [CORDIC_STEPS] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128,
      34'sd64,        34'sd32,        34'sd16,        34'sd8,
      34'sd4,         34'sd2
   };

   typedef enum logic [1:0] {
      MODE_START,
      MODE_END,
      MODE_LINEAR,
      MODE_SLERP
   } mode_type;

   typedef struct packed {
      mode_type                    mode;
      q16_type [LANES-1:0]         a;
      q17_type [LANES-1:0]         e;
      logic [16:0]                 t;
      logic [30:0]                 d;
      p36_type [LANES-1:0]         prod;
      logic [61:0]                 sqo;
      r_type [LANES-1:0]           r;
      sq_type [LANES-1:0]          rsq;
      logic [63:0]                 sqv;
      logic [63:0]                 sqr;
      w_type                       cx;
      w_type                       cy;
      w_type                       cz;
      logic [47:0]                 thp;
      logic [31:0]                 den;
      logic                        ysz;
      logic [LANES-1:0][31:0]      dlo;
      logic [LANES-1:0][32:0]      drem;
      logic [LANES-1:0][31:0]      dquo;
      logic [LANES-1:0]            dovf;
      logic [LANES-1:0]            dneg;
      w_type                       s0;
      w_type                       s1;
      logic [61:0]                 ds1;
      pw_type [LANES-1:0]          pa;
      pw_type [LANES-1:0]          pe;
      q16_type [LANES-1:0]         res;
   } pipe_type;

   typedef struct packed {
      logic     vld;
      pipe_type data;
   } slot_type;

   // Clamp a value to the unit component range
   function automatic q16_type sat_comp(input logic signed [63:0] v);
      q16_type o;
      if (v > 64'(SAT_HI)) begin
         o = SAT_HI;
      end else if (v < -64'(SAT_HI)) begin
         o = -SAT_HI;
      end else begin
         o = v[15:0];
      end
      return o;
   endfunction

endpackage

FILE: design/qslerp_ifs.sv
// ---------------------------------------------------------------------------
// qslerp channel interfaces
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
interface qslerp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] start_x;
   logic signed [15:0] start_y;
   logic signed [15:0] start_z;
   logic signed [15:0] start_w;
   logic signed [15:0] end_x;
   logic signed [15:0] end_y;
   logic signed [15:0] end_z;
   logic signed [15:0] end_w;
   logic [16:0]        fraction;
   modport source (output valid, start_x, start_y, start_z, start_w,
                   end_x, end_y, end_z, end_w, fraction, input ready);
   modport sink   (input valid, start_x, start_y, start_z, start_w,
                   end_x, end_y, end_z, end_w, fraction, output ready);
endinterface

interface qslerp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_z;
   logic signed [15:0] out_w;
   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

interface qslerp_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: design/qslerp_front.sv
// ---------------------------------------------------------------------------
// qslerp_front
// Dot product, path choice, short-arc flip, lerp terms and root operand.
// ---------------------------------------------------------------------------
module qslerp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic [14:0]          threshold,
   input  qslerp_pkg::slot_type in_slot,
   output qslerp_pkg::slot_type out_slot
);

   localparam int NS = qslerp_pkg::FRONT_STAGES;

   qslerp_pkg::slot_type prv   [NS];
   qslerp_pkg::slot_type st_in [NS];
   qslerp_pkg::slot_type st_ff [NS];

   assign prv[0] = in_slot;
   for (genvar k = 1; k < NS; k++) begin : g_link
      assign prv[k] = st_ff[k-1];
   end

   // Form the four component products of the dot
   always_comb begin : s0_mult
      st_in[0] = prv[0];
      for (int i = 0; i < qslerp_pkg::LANES; i++) begin
         st_in[0].data.prod[i] = prv[0].data.a[i] * prv[0].data.e[i];
      end
   end

   // Sum the dot, choose the path and flip the end for the short arc
   always_comb begin : s1_dot
      logic signed [35:0] dsum;
      logic [35:0]        dabs;
      logic               mid;
      st_in[1] = prv[1];
      dsum = prv[1].data.prod[0] + prv[1].data.prod[1]
           + prv[1].data.prod[2] + prv[1].data.prod[3];
      mid  = (prv[1].data.t != 17'd0) && (prv[1].data.t < qslerp_pkg::FRACTION_ONE);
      dabs = (dsum < 0) ? -dsum : dsum;
      priority if (prv[1].data.t == 17'd0) begin
         st_in[1].data.mode = qslerp_pkg::MODE_START;
      end else if (!mid) begin
         st_in[1].data.mode = qslerp_pkg::MODE_END;
      end else if (dabs > ({21'd0, threshold} << qslerp_pkg::FRACTION_BITS)) begin
         st_in[1].data.mode = qslerp_pkg::MODE_LINEAR;
      end else begin
         st_in[1].data.mode = qslerp_pkg::MODE_SLERP;
      end
      if (mid && (dsum < 0)) begin
         for (int i = 0; i < qslerp_pkg::LANES; i++) begin
            st_in[1].data.e[i] = -prv[1].data.e[i];
         end
      end
      st_in[1].data.d = (dabs > qslerp_pkg::DOT_ONE) ? qslerp_pkg::W_ONE
                                                     : {dabs[28:0], 2'b00};
   end

   // Scale the lerp differences and square the dot
   always_comb begin : s2_terms
      st_in[2] = prv[2];
      for (int i = 0; i < qslerp_pkg::LANES; i++) begin
         st_in[2].data.prod[i] = $signed({1'b0, prv[2].data.t})
                               * (prv[2].data.e[i] - prv[2].data.a[i]);
      end
      st_in[2].data.sqo = prv[2].data.d * prv[2].data.d;
   end

   // Round the lerp components and form one minus dot squared
   always_comb begin : s3_round
      logic signed [36:0] racc;
      st_in[3] = prv[3];
      for (int i = 0; i < qslerp_pkg::LANES; i++) begin
         racc = prv[3].data.a[i] * 37'sd65536 + prv[3].data.prod[i] + 37'sd128;
         st_in[3].data.r[i] = racc[34:8];
      end
      st_in[3].data.sqo = qslerp_pkg::SQ_ONE - prv[3].data.sqo;
   end

   // Square the lerp components
   always_comb begin : s4_square
      st_in[4] = prv[4];
      for (int i = 0; i < qslerp_pkg::LANES; i++) begin
         st_in[4].data.rsq[i] = prv[4].data.r[i] * prv[4].data.r[i];
      end
   end

   // Pick the root operand for the path in use
   always_comb begin : s5_select
      logic [55:0] lsum;
      st_in[5] = prv[5];
      lsum = prv[5].data.rsq[0] + prv[5].data.rsq[1]
           + prv[5].data.rsq[2] + prv[5].data.rsq[3];
      st_in[5].data.sqv = (prv[5].data.mode == qslerp_pkg::MODE_LINEAR) ? 64'(lsum)
                                                                     : 64'(prv[5].data.sqo);
      st_in[5].data.sqr = '0;
   end

   // Advance the stages, clear valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) st_ff[k].vld <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NS; k++) st_ff[k] <= st_in[k];
      end
   end

   assign out_slot = st_ff[NS-1];

endmodule

FILE: design/qslerp_isqrt.sv
// ---------------------------------------------------------------------------
// qslerp_isqrt
// Pipelined floor square root of a 64-bit operand, two result bits a stage.
// ---------------------------------------------------------------------------
module qslerp_isqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  qslerp_pkg::slot_type in_slot,
   output qslerp_pkg::slot_type out_slot
);

   localparam int NS = qslerp_pkg::SQRT_STAGES;

   qslerp_pkg::slot_type prv   [NS];
   qslerp_pkg::slot_type st_in [NS];
   qslerp_pkg::slot_type st_ff [NS];

   assign prv[0] = in_slot;
   for (genvar k = 1; k < NS; k++) begin : g_link
      assign prv[k] = st_ff[k-1];
   end

   // Try each bit pair of the operand, subtract where it fits
   for (genvar k = 0; k < NS; k++) begin : g_stage
      always_comb begin
         logic [63:0] v;
         logic [63:0] r;
         logic [63:0] b;
         st_in[k] = prv[k];
         v = prv[k].data.sqv;
         r = prv[k].data.sqr;
         for (int j = 0; j < qslerp_pkg::STEPS_PER_STAGE; j++) begin
            b = 64'd1 << (62 - 2 * (qslerp_pkg::STEPS_PER_STAGE * k + j));
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
         end
         st_in[k].data.sqv = v;
         st_in[k].data.sqr = r;
      end
   end

   // Advance the stages, clear valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) st_ff[k].vld <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NS; k++) st_ff[k] <= st_in[k];
      end
   end

   assign out_slot = st_ff[NS-1];

endmodule

FILE: design/qslerp_angle.sv
// ---------------------------------------------------------------------------
// qslerp_angle
// CORDIC arccosine, angle scaling by t, then CORDIC sine and cosine.
// ---------------------------------------------------------------------------
module qslerp_angle (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  qslerp_pkg::slot_type in_slot,
   output qslerp_pkg::slot_type out_slot
);

   localparam int NS = qslerp_pkg::ANGLE_STAGES;
   localparam int CS = qslerp_pkg::CORDIC_STAGES;
   localparam int SP = qslerp_pkg::STEPS_PER_STAGE;

   qslerp_pkg::slot_type prv   [NS];
   qslerp_pkg::slot_type st_in [NS];
   qslerp_pkg::slot_type st_ff [NS];

   assign prv[0] = in_slot;
   for (genvar k = 1; k < NS; k++) begin : g_link
      assign prv[k] = st_ff[k-1];
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      if (k < CS) begin : g_vec
         // Rotate (dot, sine) onto the x axis, accumulate the angle
         always_comb begin
            qslerp_pkg::w_type x, y, z, dx, dy;
            st_in[k] = prv[k];
            if (k == 0) begin
               x = $signed({3'b000, prv[k].data.d});
               y = $signed({2'b00, prv[k].data.sqr[31:0]});
               z = '0;
            end else begin
               x = prv[k].data.cx;
               y = prv[k].data.cy;
               z = prv[k].data.cz;
            end
            for (int j = 0; j < SP; j++) begin
               dx = y >>> (SP * k + j);
               dy = x >>> (SP * k + j);
               if (y >= 0) begin
                  x = x + dx;
                  y = y - dy;
                  z = z + qslerp_pkg::ATAN_TAB[SP * k + j];
               end else begin
                  x = x - dx;
                  y = y + dy;
                  z = z - qslerp_pkg::ATAN_TAB[SP * k + j];
               end
            end
            st_in[k].data.cx = x;
            st_in[k].data.cy = y;
            st_in[k].data.cz = z;
         end
      end else if (k == CS) begin : g_scale
         // Clamp the angle to a quarter turn and scale it by t
         always_comb begin
            logic [30:0] zc;
            st_in[k] = prv[k];
            if (prv[k].data.cz < 0) begin
               zc = '0;
            end else if (prv[k].data.cz > $signed({3'b000, qslerp_pkg::HALF_PI_W})) begin
               zc = qslerp_pkg::HALF_PI_W;
            end else begin
               zc = prv[k].data.cz[30:0];
            end
            st_in[k].data.thp = zc * prv[k].data.t;
         end
      end else begin : g_rot
         // Rotate the unit vector through the scaled angle
         always_comb begin
            qslerp_pkg::w_type x, y, z, dx, dy;
            logic [47:0] thr;
            st_in[k] = prv[k];
            thr = (prv[k].data.thp + 48'd32768) >> 16;
            if (k == CS + 1) begin
               x = qslerp_pkg::CORDIC_GAIN_INV;
               y = '0;
               z = $signed({3'b000, thr[30:0]});
            end else begin
               x = prv[k].data.cx;
               y = prv[k].data.cy;
               z = prv[k].data.cz;
            end
            for (int j = 0; j < SP; j++) begin
               dx = y >>> (SP * (k - CS - 1) + j);
               dy = x >>> (SP * (k - CS - 1) + j);
               if (z >= 0) begin
                  x = x - dx;
                  y = y + dy;
                  z = z - qslerp_pkg::ATAN_TAB[SP * (k - CS - 1) + j];
               end else begin
                  x = x + dx;
                  y = y - dy;
                  z = z + qslerp_pkg::ATAN_TAB[SP * (k - CS - 1) + j];
               end
            end
            st_in[k].data.cx = x;
            st_in[k].data.cy = y;
            st_in[k].data.cz = z;
         end
      end
   end

   // Advance the stages, clear valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) st_ff[k].vld <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NS; k++) st_ff[k] <= st_in[k];
      end
   end

   assign out_slot = st_ff[NS-1];

endmodule

FILE: design/qslerp_div.sv
// ---------------------------------------------------------------------------
// qslerp_div
// Four-lane rounded divider by the shared root, two quotient bits a stage.
// ---------------------------------------------------------------------------
module qslerp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  qslerp_pkg::slot_type in_slot,
   output qslerp_pkg::slot_type out_slot
);

   localparam int NS = qslerp_pkg::DIV_STAGES;
   localparam int SP = qslerp_pkg::STEPS_PER_STAGE;

   qslerp_pkg::slot_type prv   [NS];
   qslerp_pkg::slot_type st_in [NS];
   qslerp_pkg::slot_type st_ff [NS];

   assign prv[0] = in_slot;
   for (genvar k = 1; k < NS; k++) begin : g_link
      assign prv[k] = st_ff[k-1];
   end

   // Load magnitudes plus half the divisor, flag quotient overflow
   always_comb begin : s0_prep
      logic [31:0]        den;
      logic signed [33:0] rw;
      logic [33:0]        mag;
      logic [63:0]        num;
      st_in[0] = prv[0];
      den = prv[0].data.sqr[31:0];
      st_in[0].data.den = den;
      st_in[0].data.ysz = (den == 32'd0);
      for (int i = 0; i < qslerp_pkg::LANES; i++) begin
         if (i == 0 && prv[0].data.mode == qslerp_pkg::MODE_SLERP) begin
            rw  = prv[0].data.cy;
            mag = (rw < 0) ? -rw : rw;
            num = {mag, 30'd0};
         end else begin
            rw  = 34'(prv[0].data.r[i]);
            mag = (rw < 0) ? -rw : rw;
            num = {16'd0, mag, 14'd0};
         end
         num = num + 64'(den >> 1);
         st_in[0].data.dneg[i] = (rw < 0);
         st_in[0].data.dovf[i] = (num[63:32] >= den);
         st_in[0].data.drem[i] = {1'b0, num[63:32]};
         st_in[0].data.dlo[i]  = num[31:0];
         st_in[0].data.dquo[i] = '0;
      end
   end

   // Shift in numerator bits, subtract the divisor where it fits
   for (genvar k = 1; k < NS; k++) begin : g_stage
      always_comb begin
         logic [32:0] rem;
         logic [31:0] lo;
         logic [31:0] q;
         st_in[k] = prv[k];
         for (int i = 0; i < qslerp_pkg::LANES; i++) begin
            rem = prv[k].data.drem[i];
            lo  = prv[k].data.dlo[i];
            q   = prv[k].data.dquo[i];
            for (int j = 0; j < SP; j++) begin
               rem = {rem[31:0], lo[31]};
               lo  = lo << 1;
               if (rem >= {1'b0, prv[k].data.den}) begin
                  rem = rem - {1'b0, prv[k].data.den};
                  q   = {q[30:0], 1'b1};
               end else begin
                  q   = {q[30:0], 1'b0};
               end
            end
            st_in[k].data.drem[i] = rem;
            st_in[k].data.dlo[i]  = lo;
            st_in[k].data.dquo[i] = q;
         end
      end
   end

   // Advance the stages, clear valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) st_ff[k].vld <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NS; k++) st_ff[k] <= st_in[k];
      end
   end

   assign out_slot = st_ff[NS-1];

endmodule

FILE: design/qslerp_back.sv
// ---------------------------------------------------------------------------
// qslerp_back
// Weights, weighted sum, saturation and result selection; last stage is
// the output register.
// ---------------------------------------------------------------------------
module qslerp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  qslerp_pkg::slot_type in_slot,
   output qslerp_pkg::slot_type out_slot
);

   localparam int NS = qslerp_pkg::BACK_STAGES;

   qslerp_pkg::slot_type prv   [NS];
   qslerp_pkg::slot_type st_in [NS];
   qslerp_pkg::slot_type st_ff [NS];

   assign prv[0] = in_slot;
   for (genvar k = 1; k < NS; k++) begin : g_link
      assign prv[k] = st_ff[k-1];
   end

   // Clamp the end weight, finish the normalised lerp components
   always_comb begin : s0_weight
      logic [30:0] s1u;
      logic [31:0] q;
      st_in[0] = prv[0];
      priority if (prv[0].data.ysz) begin
         s1u = {prv[0].data.t, 14'd0};
      end else if (prv[0].data.dneg[0]) begin
         s1u = '0;
      end else if (prv[0].data.dovf[0] || prv[0].data.dquo[0] > 32'(qslerp_pkg::W_ONE)) begin
         s1u = qslerp_pkg::W_ONE;
      end else begin
         s1u = prv[0].data.dquo[0][30:0];
      end
      st_in[0].data.s1  = $signed({3'b000, s1u});
      st_in[0].data.ds1 = prv[0].data.d * s1u;
      for (int i = 0; i < qslerp_pkg::LANES; i++) begin
         q = prv[0].data.dquo[i];
         if (prv[0].data.den == 32'd0) begin
            st_in[0].data.res[i] = '0;
         end else if (prv[0].data.dovf[i] || q > 32'(qslerp_pkg::SAT_HI)) begin
            st_in[0].data.res[i] = prv[0].data.dneg[i] ? -qslerp_pkg::SAT_HI
                                                       : qslerp_pkg::SAT_HI;
         end else begin
            st_in[0].data.res[i] = prv[0].data.dneg[i] ? -q[15:0] : q[15:0];
         end
      end
   end

   // Form the start weight
   always_comb begin : s1_start_weight
      logic [61:0] rnd;
      st_in[1] = prv[1];
      rnd = (prv[1].data.ds1 + (62'd1 << (qslerp_pkg::WP - 1))) >> qslerp_pkg::WP;
      if (prv[1].data.ysz) begin
         st_in[1].data.s0 = $signed({3'b000, qslerp_pkg::W_ONE}) - prv[1].data.s1;
      end else begin
         st_in[1].data.s0 = prv[1].data.cx - $signed({2'b00, rnd[31:0]});
      end
   end

   // Weight both quaternions
   always_comb begin : s2_products
      st_in[2] = prv[2];
      for (int i = 0; i < qslerp_pkg::LANES; i++) begin
         st_in[2].data.pa[i] = prv[2].data.a[i] * prv[2].data.s0;
         st_in[2].data.pe[i] = prv[2].data.e[i] * prv[2].data.s1;
      end
   end

   // Sum, round, saturate and pick the result for the path
   always_comb begin : s3_result
      logic signed [51:0] acc;
      st_in[3] = prv[3];
      for (int i = 0; i < qslerp_pkg::LANES; i++) begin
         acc = prv[3].data.pa[i] + prv[3].data.pe[i] + 52'sd536870912;
         unique case (prv[3].data.mode)
            qslerp_pkg::MODE_START: begin
               st_in[3].data.res[i] = qslerp_pkg::sat_comp(64'(prv[3].data.a[i]));
            end
            qslerp_pkg::MODE_END: begin
               st_in[3].data.res[i] = qslerp_pkg::sat_comp(64'(prv[3].data.e[i]));
            end
            qslerp_pkg::MODE_LINEAR: begin
               st_in[3].data.res[i] = prv[3].data.res[i];
            end
            qslerp_pkg::MODE_SLERP: begin
               st_in[3].data.res[i] = qslerp_pkg::sat_comp(64'(acc >>> qslerp_pkg::WP));
            end
            default: begin
               st_in[3].data.res[i] = prv[3].data.res[i];
            end
         endcase
      end
   end

   // Advance the stages, clear valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) st_ff[k].vld <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NS; k++) st_ff[k] <= st_in[k];
      end
   end

   assign out_slot = st_ff[NS-1];

endmodule

FILE: design/quaternion_slerp_top.sv
// ---------------------------------------------------------------------------
// quaternion_slerp_top
// Pipelined spherical linear interpolation between two unit quaternions.
// ---------------------------------------------------------------------------
// Channels: req_chan takes one item (start and end quaternions in Q1.14 and
// a fraction in Q1.16); rsp_chan returns one interpolated quaternion per
// item, in order. csr_chan writes the near threshold (Q1.14); it is always
// ready and should be written only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. Every
// item, whatever its path, runs the same fixed-length pipeline: dot and lerp
// terms (6 stages), square root (16), arccosine/sine/cosine CORDIC pair with
// angle scaling (31), divider (17) and weighting/saturation (4).
// Depth: set by the two 30-step CORDIC units and the 32-step root and divide.
// Reset: all stage valid bits clear, the pipeline is empty, req_chan.ready
// is held low and the threshold returns to 16376 (about 0.9995).
// Stall: while a result is offered and not taken, the whole pipeline holds
// and req_chan.ready stays low; nothing is dropped or repeated. With the
// receiver ready, a new item is taken every cycle.
// ---------------------------------------------------------------------------
`include "quaternion_slerp_top_assert.svh"

module quaternion_slerp_top (
   input  logic         clock,
   input  logic         reset,
   qslerp_req_if.sink   req_chan,
   qslerp_rsp_if.source rsp_chan,
   qslerp_csr_if.sink   csr_chan
);

   logic [14:0]          thr_ff;
   logic [14:0]          thr_in;
   logic                 adv;
   qslerp_pkg::slot_type req_slot;
   qslerp_pkg::slot_type front_out;
   qslerp_pkg::slot_type sqrt_out;
   qslerp_pkg::slot_type angle_out;
   qslerp_pkg::slot_type div_out;
   qslerp_pkg::slot_type back_out;

   // Take register writes at any time
   assign csr_chan.ready = 1'b1;
   assign thr_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= qslerp_pkg::THRESHOLD_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // Advance the pipeline unless the output item is held
   assign adv = !back_out.vld || rsp_chan.ready;
   assign req_chan.ready = adv && !reset;

   // Pack the request item
   always_comb begin
      req_slot           = '0;
      req_slot.vld       = req_chan.valid;
      req_slot.data.a[0] = req_chan.start_x;
      req_slot.data.a[1] = req_chan.start_y;
      req_slot.data.a[2] = req_chan.start_z;
      req_slot.data.a[3] = req_chan.start_w;
      req_slot.data.e[0] = 17'(req_chan.end_x);
      req_slot.data.e[1] = 17'(req_chan.end_y);
      req_slot.data.e[2] = 17'(req_chan.end_z);
      req_slot.data.e[3] = 17'(req_chan.end_w);
      req_slot.data.t    = req_chan.fraction;
   end

   qslerp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .threshold (thr_ff),
      .in_slot   (req_slot),
      .out_slot  (front_out)
   );

   qslerp_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_slot  (front_out),
      .out_slot (sqrt_out)
   );

   qslerp_angle u_angle (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_slot  (sqrt_out),
      .out_slot (angle_out)
   );

   qslerp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_slot  (angle_out),
      .out_slot (div_out)
   );

   qslerp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_slot  (div_out),
      .out_slot (back_out)
   );

   // Drive the response item from the output register
   assign rsp_chan.valid = back_out.vld;
   assign rsp_chan.out_x = back_out.data.res[0];
   assign rsp_chan.out_y = back_out.data.res[1];
   assign rsp_chan.out_z = back_out.data.res[2];
   assign rsp_chan.out_w = back_out.data.res[3];

   `QS_ASSERT_SAME(a_stall_blocks_req, rsp_chan.valid && !rsp_chan.ready,
      !req_chan.ready, "request taken while the output item is stalled")
   `QS_ASSERT_NEXT(a_csr_write, csr_chan.valid && csr_chan.ready,
      thr_ff == $past(csr_chan.data), "threshold write not captured")
   `QS_ASSERT_SAME(a_empty_after_reset, $fell(reset),
      !rsp_chan.valid, "response offered straight after reset")

endmodule

FILE: bench/tb_quaternion_slerp_top.sv
// ---------------------------------------------------------------------------
// tb_quaternion_slerp_top
// Self-checking bench for the quaternion slerp pipeline: a directed table
// of end cases, then random quaternion pairs over several near thresholds,
// each result checked lane by lane against a bit-exact predictor or a fixed value.
// ---------------------------------------------------------------------------
module tb_quaternion_slerp_top;

   localparam int LATENCY    = 74;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_RANDOM   = 1925;

   typedef struct {
      logic signed [15:0] a [4];
      logic signed [15:0] e [4];
      logic [16:0]        t;
   } quat_pair_type;

   typedef struct {
      logic signed [15:0] q [4];
   } quat_type;

   typedef struct {
      quat_pair_type in;
      logic          has_fixed;
      quat_type      fixed;
   } table_row_type;

   logic clock;
   logic reset;

   qslerp_req_if req_chan ();
   qslerp_rsp_if rsp_chan ();
   qslerp_csr_if csr_chan ();

   quaternion_slerp_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   logic [14:0] threshold;
   quat_type    pending_quats [$];
   int          mismatch_count;
   int          result_count;
   int          accepted_count;
   int          idle_cycles;
   bit          hold_off;
   bit          stim_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // floor(v / 2^s)
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint div_round(longint n, longint d);
      longint unsigned m, q;
      m = n < 0 ? longint'(-n) : n;
      q = (m + longint'(d) / 2) / longint'(d);
      return n < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] clamp_lane(longint v);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
   endfunction

   // work out the interpolated quaternion for one item
   function automatic quat_type slerp_predict(quat_pair_type p, logic [14:0] thr);
      quat_type        o;
      longint          a [4], e [4], r [4];
      longint          dot, d, x, y, z, dx, dy, th, s0, s1, c, s;
      longint unsigned len2, len, ys, t;
      t = p.t;
      for (int i = 0; i < 4; i++) begin
         a[i] = p.a[i];
         e[i] = p.e[i];
      end
      if (t == 0) begin
         for (int i = 0; i < 4; i++) o.q[i] = clamp_lane(a[i]);
         return o;
      end
      if (t >= 65536) begin
         for (int i = 0; i < 4; i++) o.q[i] = clamp_lane(e[i]);
         return o;
      end
      dot = 0;
      for (int i = 0; i < 4; i++) dot += a[i] * e[i];
      if (dot < 0) begin
         dot = -dot;
         for (int i = 0; i < 4; i++) e[i] = -e[i];
      end
      // normalised linear path near the start quaternion
      if (dot > (longint'(thr) << 14)) begin
         len2 = 0;
         for (int i = 0; i < 4; i++) begin
            r[i] = round_shift(a[i] * 65536 + longint'(t) * (e[i] - a[i]), 8);
            len2 += longint'(r[i] * r[i]);
         end
         len = int_sqrt(len2);
         for (int i = 0; i < 4; i++)
            o.q[i] = len == 0 ? 16'sd0 : clamp_lane(div_round(r[i] * 16384, len));
         return o;
      end
      d = dot * 4;
      if (d > (longint'(1) << 30)) d = longint'(1) << 30;
      ys = int_sqrt((64'd1 << 60) - longint'(d * d));
      // arccosine by vectoring
      x = d; y = ys; z = 0;
      for (int i = 0; i < qslerp_pkg::CORDIC_STEPS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += qslerp_pkg::ATAN_TAB[i];
         end else begin
            x -= dx; y += dy; z -= qslerp_pkg::ATAN_TAB[i];
         end
      end
      if (z < 0) z = 0;
      if (z > qslerp_pkg::HALF_PI_W) z = qslerp_pkg::HALF_PI_W;
      th = (longint'(z) * longint'(t) + 32768) >> 16;
      // sine and cosine by rotation
      x = qslerp_pkg::CORDIC_GAIN_INV; y = 0; z = th;
      for (int i = 0; i < qslerp_pkg::CORDIC_STEPS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= qslerp_pkg::ATAN_TAB[i];
         end else begin
            x += dx; y -= dy; z += qslerp_pkg::ATAN_TAB[i];
         end
      end
      c = x; s = y;
      if (ys == 0) begin
         s1 = longint'(t) << 14;
         s0 = (longint'(1) << 30) - s1;
      end else begin
         s1 = div_round(s * (longint'(1) << 30), ys);
         if (s1 < 0) s1 = 0;
         if (s1 > (longint'(1) << 30)) s1 = longint'(1) << 30;
         s0 = c - round_shift(d * s1, 30);
      end
      for (int i = 0; i < 4; i++)
         o.q[i] = clamp_lane(round_shift(a[i] * s0 + e[i] * s1, 30));
      return o;
   endfunction

   function automatic int short_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) :
             ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
   endfunction

   // a random unit-ish component set, or noise over the whole field
   function automatic quat_pair_type random_pair();
      quat_pair_type p;
      int            kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) begin
         p.a[i] = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
         p.e[i] = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      end
      if (kind < 7) begin
         // normalise both to unit length, end close to start sometimes
         real la, le;
         la = 0; le = 0;
         for (int i = 0; i < 4; i++) la += real'(p.a[i]) * real'(p.a[i]);
         if (la == 0) p.a[3] = 16'sd16384;
         else for (int i = 0; i < 4; i++)
            p.a[i] = 16'($rtoi(real'(p.a[i]) * 16384.0 / $sqrt(la)));
         if (kind < 3) begin
            for (int i = 0; i < 4; i++)
               p.e[i] = p.a[i] + $signed(16'($urandom_range(0, 400))) - 16'sd200;
            if (kind == 0) for (int i = 0; i < 4; i++) p.e[i] = -p.e[i];
         end
         for (int i = 0; i < 4; i++) le += real'(p.e[i]) * real'(p.e[i]);
         if (le == 0) p.e[0] = 16'sd16384;
         else for (int i = 0; i < 4; i++)
            p.e[i] = 16'($rtoi(real'(p.e[i]) * 16384.0 / $sqrt(le)));
      end else if (kind == 9) begin
         for (int i = 0; i < 4; i++) begin
            p.a[i] = 16'($urandom);
            p.e[i] = 16'($urandom);
         end
      end
      case ($urandom_range(0, 19))
         0:       p.t = 17'd0;
         1:       p.t = qslerp_pkg::FRACTION_ONE;
         2:       p.t = 17'($urandom_range(65537, 131071));
         3:       p.t = 17'($urandom_range(1, 3));
         default: p.t = 17'($urandom_range(1, 65535));
      endcase
      return p;
   endfunction

   task automatic send_item(quat_pair_type p);
      int gap;
      gap = short_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.start_x  <= p.a[0];
      req_chan.start_y  <= p.a[1];
      req_chan.start_z  <= p.a[2];
      req_chan.start_w  <= p.a[3];
      req_chan.end_x    <= p.e[0];
      req_chan.end_y    <= p.e[1];
      req_chan.end_z    <= p.e[2];
      req_chan.end_w    <= p.e[3];
      req_chan.fraction <= p.t;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_quats.push_back(slerp_predict(p, threshold));
      accepted_count++;
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      req_chan.valid <= 1'b0;
      while (pending_quats.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_threshold(logic [14:0] v);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= v;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      threshold = v;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic quat_pair_type make_pair(int ax, int ay, int az, int aw,
                                               int ex, int ey, int ez, int ew, int t);
      quat_pair_type p;
      p.a = '{16'(ax), 16'(ay), 16'(az), 16'(aw)};
      p.e = '{16'(ex), 16'(ey), 16'(ez), 16'(ew)};
      p.t = 17'(t);
      return p;
   endfunction

   // stimulus
   initial begin
      table_row_type rows [$];
      table_row_type row;
      logic [14:0]   thr_plan [5];
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.start_x = '0; req_chan.start_y = '0;
      req_chan.start_z = '0; req_chan.start_w = '0;
      req_chan.end_x   = '0; req_chan.end_y   = '0;
      req_chan.end_z   = '0; req_chan.end_w   = '0;
      req_chan.fraction = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.data    = '0;
      threshold        = qslerp_pkg::THRESHOLD_RESET;
      stim_done        = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed table; fixed results only where they follow at a glance
      row.has_fixed = 1'b1;
      row.in = make_pair(16384, -16384, 32767, -32768, 1, 2, 3, 4, 0);
      row.fixed.q = '{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384};
      rows.push_back(row);
      row.in = make_pair(1, 2, 3, 4, -32768, 32767, -5, 7, 65536);
      row.fixed.q = '{-16'sd16384, 16'sd16384, -16'sd5, 16'sd7};
      rows.push_back(row);
      row.in = make_pair(1, 2, 3, 4, -100, 100, 16384, -16384, 131071);
      row.fixed.q = '{-16'sd100, 16'sd100, 16'sd16384, -16'sd16384};
      rows.push_back(row);
      row.in = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 30000);
      row.fixed.q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
      rows.push_back(row);
      row.has_fixed = 1'b0;
      row.in = make_pair(0, 0, 0, 16384, 0, 0, 0, 16384, 32768);
      rows.push_back(row);
      row.in = make_pair(0, 0, 0, 16384, 0, 0, 0, -16384, 32768);
      rows.push_back(row);
      row.in = make_pair(0, 0, 0, 16384, 16384, 0, 0, 0, 32768);
      rows.push_back(row);
      row.in = make_pair(0, 0, 0, 16384, 11585, 0, 0, 11585, 1);
      rows.push_back(row);
      row.in = make_pair(0, 0, 0, 16384, 11585, 0, 0, -11585, 65535);
      rows.push_back(row);
      row.in = make_pair(16384, 16384, 0, 0, 16384, 16384, 0, 0, 20000);
      rows.push_back(row);
      row.in = make_pair(32767, 32767, 32767, 32767, -32768, -32768, -32768,
                         -32768, 40000);
      rows.push_back(row);
      row.in = make_pair(8192, 8192, 8192, 8192, 8192, 8192, 8192, 8190, 12345);
      rows.push_back(row);
      row.in = make_pair(0, 6000, 0, 15250, 0, -6000, 0, 15250, 50000);
      rows.push_back(row);
      row.in = make_pair(-32768, 0, 0, 0, 32767, 0, 0, 0, 100);
      rows.push_back(row);
      foreach (rows[k]) begin
         send_item(rows[k].in);
         if (rows[k].has_fixed) pending_quats[$] = rows[k].fixed;
      end
      req_chan.valid <= 1'b0;

      // random part over several thresholds, extremes included
      thr_plan = '{15'd0, 15'd16384, 15'd32767, 15'd12000, 15'd16000};
      for (int ph = 0; ph < 6; ph++) begin
         drain_and_settle();
         if (ph > 0) write_threshold(thr_plan[ph - 1]);
         else write_threshold(15'($urandom_range(16300, 16383)));
         if (ph == 2) hold_off = 1'b1;
         repeat (N_RANDOM / 6) send_item(random_pair());
         req_chan.valid <= 1'b0;
      end
      drain_and_settle();
      stim_done = 1'b1;
   end

   // receiver: random stalls, plus one long hold-off while the input backs up
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? short_gap() : 0;
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      quat_type want;
      quat_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.q = '{rsp_chan.out_x, rsp_chan.out_y, rsp_chan.out_z, rsp_chan.out_w};
         result_count++;
         if (pending_quats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %0d %0d %0d %0d", got.q[0], got.q[1],
                        got.q[2], got.q[3]);
         end else begin
            want = pending_quats.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (got.q[i] !== want.q[i]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d lane %0d: expected %0d, got %0d",
                              result_count, i, want.q[i], got.q[i]);
               end
            end
         end
      end
   end

   // watchdog on cycles with no item moving, and end of run
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (stim_done) begin
         $display("Ran %0d items through thresholds 0 to max with stalls;", accepted_count);
         $display("%0d results checked, %0d mismatches.", result_count, mismatch_count);
         if (mismatch_count == 0 && pending_quats.size() == 0)
            $display("PASS");
         else
            $display("FAIL");
         $finish;
      end else if (idle_cycles > IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      mismatch_count = 0;
      result_count   = 0;
      accepted_count = 0;
      idle_cycles    = 0;
      hold_off       = 1'b0;
   end

endmodule

FILE: files.f
+incdir+design
design/qslerp_pkg.sv
design/qslerp_ifs.sv
design/qslerp_front.sv
design/qslerp_isqrt.sv
design/qslerp_angle.sv
design/qslerp_div.sv
design/qslerp_back.sv
design/quaternion_slerp_top.sv
bench/tb_quaternion_slerp_top.sv
